/* rtl/deq_pkg.sv */
// Shared types and sizing constants for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

  localparam int DEPTH    = 1024;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int VALUE_W  = 64;
  localparam int COUNT_W  = 11;

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_SIZE       = 3'd6,
    OP_CLEAR      = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // At most one memory access issued for an accepted word.
  typedef struct packed {
    logic   wr_en;
    logic   rd_en;
    idx_t   addr;
    value_t wr_data;
  } mem_req_t;

endpackage
`default_nettype wire

/* rtl/deq_in_if.sv */
// Request channel: opcode and value with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface deq_in_if;
  import deq_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  value_t  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface
`default_nettype wire

/* rtl/deq_out_if.sv */
// Response channel: status, data and count with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface deq_out_if;
  import deq_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  value_t  data;
  count_t  count;

  modport source (output valid, output status, output data, output count, input ready);
  modport sink   (input valid, input status, input data, input count, output ready);
endinterface
`default_nettype wire

/* rtl/deq_ram.sv */
// Entry storage: single-port synchronous RAM (one shared address), registered read.
`timescale 1ns / 1ps
`default_nettype none
module deq_ram (
  input  wire logic              clk,
  input  wire deq_pkg::mem_req_t req,
  output deq_pkg::value_t        rd_data
);
  import deq_pkg::*;

  value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/double_ended_queue.sv */
// Top level of the double-ended queue of signed 64-bit values.
//
// Double-ended queue held in a ring buffer of DEPTH 64-bit entries (one
// synchronous RAM). Every request word gives exactly one response word with
// a status (ok, empty, full), the popped or peeked data (zero otherwise) and
// the entry count after the operation. Pointers and count live in flops and
// are updated in the cycle a request is accepted; that same cycle issues the
// RAM access, if any (write for a successful push, read for a successful pop
// or peek). The RAM returns read data from its registered read port while the
// response is formed in a pending stage, then moved into the output register.
// Throughput is one word per clock while the response side keeps taking words.
// A push is visible to a pop in the very next cycle, since the RAM write lands
// at the accepting edge. Clear only resets pointers and count; stored data is
// left in place. No clearing pass runs after reset: the block is ready in the
// first cycle.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue (
  input  wire logic clk,
  input  wire logic rst,
  deq_in_if.sink    req,
  deq_out_if.source rsp
);
  import deq_pkg::*;

  localparam idx_t IDX_LAST = IDX_W'(DEPTH - 1);
  localparam cnt_t CNT_FULL = CNT_W'(DEPTH);

  // Ring state
  idx_t head, head_next;
  idx_t tail, tail_next;
  cnt_t cnt, cnt_next;

  // Pending stage: holds a word while RAM read data arrives
  logic    pend_valid;
  status_t pend_status;
  logic    pend_read;
  cnt_t    pend_cnt;

  // Output register
  logic    out_valid;
  status_t out_status;
  value_t  out_data;
  count_t  out_count;

  mem_req_t mreq;
  value_t   rd_data;
  status_t  st;
  logic     is_read;
  logic     acc;
  logic     out_load;
  logic     empty, full;
  idx_t     head_inc, head_dec, tail_inc, tail_dec;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  // Pending word moves to output when the output register is free or draining.
  assign out_load  = pend_valid && (!out_valid || rsp.ready);
  assign req.ready = !pend_valid || out_load;
  assign acc       = req.valid && req.ready;

  assign empty = (cnt == '0);
  assign full  = (cnt == CNT_FULL);

  assign head_inc = (head == IDX_LAST) ? '0 : head + idx_t'(1);
  assign head_dec = (head == '0) ? IDX_LAST : head - idx_t'(1);
  assign tail_inc = (tail == IDX_LAST) ? '0 : tail + idx_t'(1);
  assign tail_dec = (tail == '0) ? IDX_LAST : tail - idx_t'(1);

  always_comb begin
    head_next    = head;
    tail_next    = tail;
    cnt_next     = cnt;
    st           = ST_OK;
    is_read      = 1'b0;
    mreq.wr_en   = 1'b0;
    mreq.rd_en   = 1'b0;
    mreq.addr    = head;
    mreq.wr_data = req.value;
    unique case (req.opcode)
      OP_PUSH_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          head_next  = head_dec;
          mreq.addr  = head_dec;
          mreq.wr_en = acc;
          cnt_next   = cnt + cnt_t'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          tail_next  = tail_inc;
          mreq.addr  = tail;
          mreq.wr_en = acc;
          cnt_next   = cnt + cnt_t'(1);
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          is_read    = 1'b1;
          mreq.addr  = head;
          mreq.rd_en = acc;
          if (req.opcode == OP_POP_FRONT) begin
            head_next = head_inc;
            cnt_next  = cnt - cnt_t'(1);
          end
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          is_read    = 1'b1;
          mreq.addr  = tail_dec;
          mreq.rd_en = acc;
          if (req.opcode == OP_POP_BACK) begin
            tail_next = tail_dec;
            cnt_next  = cnt - cnt_t'(1);
          end
        end
      end
      OP_SIZE: begin
      end
      OP_CLEAR: begin
        head_next = '0;
        tail_next = '0;
        cnt_next  = '0;
      end
      default: begin
      end
    endcase
  end

  deq_ram u_ram (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      cnt        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (acc) begin
        head <= head_next;
        tail <= tail_next;
        cnt  <= cnt_next;
      end
      if (acc) begin
        pend_valid <= 1'b1;
      end else if (out_load) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  assign cnt_ext = {{COUNT_W{1'b0}}, pend_cnt};

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_status <= st;
      pend_read   <= is_read;
      pend_cnt    <= cnt_next;
    end
    if (out_load) begin
      out_status <= pend_status;
      out_data   <= pend_read ? rd_data : '0;
      out_count  <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.data   = out_data;
  assign rsp.count  = out_count;

endmodule
`default_nettype wire
